// ===== rtl/midi_track_note_duration_extractor_unit_assert.svh =====
// Assertion macros for the note duration extractor
`ifndef MIDI_TRACK_NOTE_DURATION_EXTRACTOR_UNIT_ASSERT_SVH
`define MIDI_TRACK_NOTE_DURATION_EXTRACTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MTN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MTN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MTN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mtnde_pkg.sv =====
package mtnde_pkg;
    localparam int ACTIVE_NOTES = 16;
    localparam int IDX_W = $clog2(ACTIVE_NOTES);
    localparam int CNT_W = $clog2(ACTIVE_NOTES + 1);

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_UNMATCHED = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    localparam logic [1:0] CMD_ON = 2'd0;
    localparam logic [1:0] CMD_OFF = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_EOT = 8'h2F;
    localparam logic [23:0] TEMPO_RESET = 24'd500000;
    localparam logic [23:0] TICK_RESET = 24'd5208;
    localparam logic [14:0] TPQ_RESET = 15'd96;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] channel;
        logic [6:0] note;
        logic [31:0] time_now;
        logic [23:0] tempo;
        logic [14:0] tpq;
    } cmd_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [6:0] note_number;
        logic [3:0] note_channel;
        logic [31:0] duration_ticks;
        logic [55:0] duration_us;
    } res_t;
endpackage

// ===== rtl/mtnde_if.sv =====
interface mtnde_in_if;
    logic valid;
    logic ready;
    logic [7:0] track_byte;
    logic track_start;
    modport source (output valid, track_byte, track_start, input ready);
    modport sink (input valid, track_byte, track_start, output ready);
endinterface

interface mtnde_out_if;
    logic valid;
    logic ready;
    logic [1:0] result_kind;
    logic [6:0] note_number;
    logic [3:0] note_channel;
    logic [31:0] duration_ticks;
    logic [55:0] duration_us;
    modport source (output valid, result_kind, note_number, note_channel, duration_ticks,
        duration_us, input ready);
    modport sink (input valid, result_kind, note_number, note_channel, duration_ticks,
        duration_us, output ready);
endinterface

interface mtnde_cfg_if;
    logic valid;
    logic ready;
    logic [14:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/mtnde_front.sv =====
module mtnde_front (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    output logic in_ready,
    input logic [7:0] track_byte,
    input logic track_start,
    input logic [14:0] tpq,
    output logic cmd_valid,
    input logic cmd_ready,
    output mtnde_pkg::cmd_t cmd
);
    import mtnde_pkg::*;

    localparam logic [2:0] PH_DELTA = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_DATA1 = 3'd2;
    localparam logic [2:0] PH_DATA2 = 3'd3;
    localparam logic [2:0] PH_MKIND = 3'd4;
    localparam logic [2:0] PH_MLEN = 3'd5;
    localparam logic [2:0] PH_MDATA = 3'd6;

    logic [2:0] phase_reg, phase_next;
    logic [31:0] delta_reg, delta_next;
    logic [31:0] time_reg, time_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] mkind_reg, mkind_next;
    logic [31:0] mrem_reg, mrem_next;
    logic [1:0] midx_reg, midx_next;
    logic [23:0] tempo_reg, tempo_next;
    logic ended_reg, ended_next;
    logic emit;
    cmd_t c;
    logic accept;
    logic [31:0] d, t, mr;
    logic [2:0] ph;
    logic en;
    logic [3:0] hi;
    logic meta_end;

    assign in_ready = cmd_ready;
    assign accept = in_valid && in_ready;
    assign cmd_valid = accept && emit;
    assign cmd = c;

    always_comb
    begin
        phase_next = phase_reg;
        delta_next = delta_reg;
        time_next = time_reg;
        status_next = status_reg;
        first_next = first_reg;
        mkind_next = mkind_reg;
        mrem_next = mrem_reg;
        midx_next = midx_reg;
        tempo_next = tempo_reg;
        ended_next = ended_reg;
        emit = 1'b0;
        meta_end = 1'b0;
        c = '0;
        c.tpq = tpq;
        c.tempo = tempo_reg;
        c.channel = status_reg[3:0];
        c.note = first_reg[6:0];
        d = delta_reg;
        t = time_reg;
        ph = phase_reg;
        en = ended_reg;
        mr = mrem_reg;
        hi = status_reg[7:4];
        if (track_start)
        begin
            d = '0;
            t = '0;
            ph = PH_DELTA;
            en = 1'b0;
            emit = 1'b1;
            c.cmd = CMD_CLEAR;
        end
        delta_next = d;
        time_next = t;
        phase_next = ph;
        ended_next = en;
        if (!en)
        begin
            unique case (ph)
                PH_DELTA:
                begin
                    delta_next = {d[24:0], track_byte[6:0]};
                    if (!track_byte[7])
                    begin
                        time_next = t + {d[24:0], track_byte[6:0]};
                        delta_next = '0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    status_next = track_byte;
                    if (track_byte == 8'hFF)
                        phase_next = PH_MKIND;
                    else if (track_byte[7] && track_byte[7:4] != 4'hF)
                        phase_next = PH_DATA1;
                    else
                        phase_next = PH_DELTA;
                end
                PH_DATA1:
                begin
                    first_next = track_byte;
                    phase_next = (hi == 4'hC || hi == 4'hD) ? PH_DELTA : PH_DATA2;
                end
                PH_DATA2:
                begin
                    phase_next = PH_DELTA;
                    if (hi == 4'h8 || hi == 4'h9)
                    begin
                        emit = 1'b1;
                        c.cmd = (hi == 4'h9 && track_byte != 8'h00) ? CMD_ON : CMD_OFF;
                        c.time_now = t;
                    end
                end
                PH_MKIND:
                begin
                    mkind_next = track_byte;
                    mrem_next = '0;
                    midx_next = '0;
                    delta_next = '0;
                    phase_next = PH_MLEN;
                end
                PH_MLEN:
                begin
                    mrem_next = {mr[24:0], track_byte[6:0]};
                    if (!track_byte[7])
                    begin
                        if ({mr[24:0], track_byte[6:0]} == '0)
                            meta_end = 1'b1;
                        else
                            phase_next = PH_MDATA;
                    end
                end
                PH_MDATA:
                begin
                    if (mkind_reg == META_TEMPO && midx_reg != 2'd3)
                    begin
                        unique case (midx_reg)
                            2'd0: delta_next = d | {8'd0, track_byte, 16'd0};
                            2'd1: delta_next = d | {16'd0, track_byte, 8'd0};
                            default: delta_next = d | {24'd0, track_byte};
                        endcase
                        midx_next = midx_reg + 2'd1;
                    end
                    mrem_next = mr - 32'd1;
                    if (mr == 32'd1)
                        meta_end = 1'b1;
                end
                default: phase_next = PH_DELTA;
            endcase
            if (meta_end)
            begin
                phase_next = PH_DELTA;
                if (mkind_reg == META_TEMPO)
                begin
                    tempo_next = delta_next[23:0];
                    emit = 1'b1;
                    c.cmd = CMD_CLEAR;
                    c.time_now = 32'd1;
                    c.tempo = delta_next[23:0];
                end
                delta_next = '0;
                if (mkind_reg == META_EOT)
                begin
                    ended_next = 1'b1;
                    emit = 1'b1;
                    c.cmd = CMD_END;
                end
            end
        end
        if (track_start)
            c.channel = 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELTA;
            delta_reg <= '0;
            time_reg <= '0;
            status_reg <= '0;
            first_reg <= '0;
            mkind_reg <= '0;
            mrem_reg <= '0;
            midx_reg <= '0;
            tempo_reg <= TEMPO_RESET;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            delta_reg <= delta_next;
            time_reg <= time_next;
            status_reg <= status_next;
            first_reg <= first_next;
            mkind_reg <= mkind_next;
            mrem_reg <= mrem_next;
            midx_reg <= midx_next;
            tempo_reg <= tempo_next;
            ended_reg <= ended_next;
        end
    end
endmodule

// ===== rtl/mtnde_back.sv =====
module mtnde_back (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    output logic cmd_ready,
    input mtnde_pkg::cmd_t cmd,
    output logic res_valid,
    input logic res_ready,
    output mtnde_pkg::res_t res
);
    import mtnde_pkg::*;
    `include "midi_track_note_duration_extractor_unit_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_DIV = 3'd3;
    localparam logic [2:0] ST_MUL = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    logic [2:0] st_reg;
    cmd_t c_reg;
    logic [3:0] ch_mem [ACTIVE_NOTES];
    logic [6:0] nt_mem [ACTIVE_NOTES];
    logic [31:0] tm_mem [ACTIVE_NOTES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [23:0] tick_reg;
    logic [23:0] quo_reg;
    logic [23:0] rem_reg;
    logic [4:0] step_reg;
    logic [31:0] ticks_reg;
    logic [55:0] prod_reg;
    res_t out_reg;
    logic out_valid_reg;
    logic [14:0] divisor;
    logic [24:0] trial;
    logic [IDX_W-1:0] ia, ib;

    assign cmd_ready = (st_reg == ST_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res = out_reg;
    assign divisor = (c_reg.tpq == '0) ? 15'd1 : c_reg.tpq;
    assign trial = {rem_reg, quo_reg[23]} - {10'd0, divisor};
    assign ia = idx_reg[IDX_W-1:0];
    assign ib = IDX_W'(idx_reg + CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && cmd.cmd == CMD_ON && count_reg != CNT_W'(ACTIVE_NOTES))
        begin
            ch_mem[count_reg[IDX_W-1:0]] <= cmd.channel;
            nt_mem[count_reg[IDX_W-1:0]] <= cmd.note;
            tm_mem[count_reg[IDX_W-1:0]] <= cmd.time_now;
        end
        else if (st_reg == ST_SHIFT && idx_reg + CNT_W'(1) < count_reg)
        begin
            ch_mem[ia] <= ch_mem[ib];
            nt_mem[ia] <= nt_mem[ib];
            tm_mem[ia] <= tm_mem[ib];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            tick_reg <= TICK_RESET;
            out_valid_reg <= 1'b0;
            c_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            step_reg <= '0;
            ticks_reg <= '0;
            prod_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && res_ready)
                out_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        c_reg <= cmd;
                        unique case (cmd.cmd)
                            CMD_ON:
                            begin
                                if (count_reg == CNT_W'(ACTIVE_NOTES))
                                begin
                                    out_reg <= '{KIND_FULL, cmd.note, cmd.channel, 32'd0, 56'd0};
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                    count_reg <= count_reg + CNT_W'(1);
                            end
                            CMD_OFF:
                            begin
                                idx_reg <= '0;
                                st_reg <= ST_SCAN;
                            end
                            CMD_END:
                            begin
                                out_reg <= '{KIND_END, 7'd0, 4'd0, 32'd0, 56'd0};
                                out_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                if (cmd.time_now == 32'd0)
                                    count_reg <= '0;
                                quo_reg <= cmd.tempo;
                                rem_reg <= '0;
                                step_reg <= '0;
                                st_reg <= ST_DIV;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        out_reg <= '{KIND_UNMATCHED, c_reg.note, c_reg.channel, 32'd0, 56'd0};
                        out_valid_reg <= 1'b1;
                        st_reg <= ST_IDLE;
                    end
                    else if (ch_mem[ia] == c_reg.channel && nt_mem[ia] == c_reg.note)
                    begin
                        ticks_reg <= c_reg.time_now - tm_mem[ia];
                        st_reg <= ST_SHIFT;
                    end
                    else
                        idx_reg <= idx_reg + CNT_W'(1);
                end
                ST_SHIFT:
                begin
                    if (idx_reg + CNT_W'(1) < count_reg)
                        idx_reg <= idx_reg + CNT_W'(1);
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        st_reg <= ST_MUL;
                    end
                end
                ST_DIV:
                begin
                    if (!trial[24])
                    begin
                        rem_reg <= trial[23:0];
                        quo_reg <= {quo_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[22:0], quo_reg[23]};
                        quo_reg <= {quo_reg[22:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd23)
                    begin
                        tick_reg <= !trial[24] ? {quo_reg[22:0], 1'b1} : {quo_reg[22:0], 1'b0};
                        st_reg <= ST_IDLE;
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= {24'd0, ticks_reg} * {32'd0, tick_reg};
                    st_reg <= ST_OUT;
                end
                default:
                begin
                    out_reg <= '{KIND_DONE, c_reg.note, c_reg.channel, ticks_reg, prod_reg};
                    out_valid_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MTN_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(ACTIVE_NOTES))
    `MTN_ASSERT_IMP(a_busy_not_ready, clk, rst_n, st_reg != ST_IDLE, !cmd_ready)
    `MTN_ASSERT_NXT(a_div_done, clk, rst_n, st_reg == ST_DIV && step_reg == 5'd23,
        st_reg == ST_IDLE)
endmodule

// ===== rtl/midi_track_note_duration_extractor_unit.sv =====
// MIDI track note duration extractor.
// in: one track byte per item with track_start on the first byte of a track.
// cfg: ticks_per_quarter write; takes effect at the next tick length update
// (track start or set-tempo).
// out: one result item per finished note, end of track, unmatched note-off
// or dropped note-on.
// A front parser takes one byte per cycle while the command queue is empty and
// hands note, tempo and track commands through that one-entry queue to a back
// engine that scans the 16-entry note table, divides tempo by ticks_per_quarter
// and multiplies the duration. A note-off result follows a table scan,
// compaction and one multiply; end of track and dropped note-on results are
// registered straight from the command. A track start or set-tempo end keeps
// the back engine busy for the serial divider.
// Reset clears the note table, track time and parser; tempo returns to
// 500000 and the tick length to 5208.
// A stalled receiver holds the result register and the back engine; one more
// command waits in the queue, after which the input stalls on every byte.
module midi_track_note_duration_extractor_unit (
    input logic clk,
    input logic rst_n,
    mtnde_in_if.sink in_ch,
    mtnde_out_if.source out_ch,
    mtnde_cfg_if.sink cfg
);
    import mtnde_pkg::*;

    logic [14:0] tpq_reg;
    logic cmd_valid, cmd_ready, q_valid_reg, back_ready;
    cmd_t cmd, q_reg;
    res_t res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tpq_reg <= TPQ_RESET;
        else if (cfg.valid)
            tpq_reg <= cfg.data;
    end

    assign cmd_ready = !q_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            q_reg <= '0;
        end
        else if (q_valid_reg)
        begin
            if (back_ready)
                q_valid_reg <= 1'b0;
        end
        else if (cmd_valid)
        begin
            q_valid_reg <= 1'b1;
            q_reg <= cmd;
        end
    end

    mtnde_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .track_byte(in_ch.track_byte),
        .track_start(in_ch.track_start),
        .tpq(tpq_reg),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd)
    );

    mtnde_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(q_valid_reg),
        .cmd_ready(back_ready),
        .cmd(q_reg),
        .res_valid(out_ch.valid),
        .res_ready(out_ch.ready),
        .res(res)
    );

    assign out_ch.result_kind = res.result_kind;
    assign out_ch.note_number = res.note_number;
    assign out_ch.note_channel = res.note_channel;
    assign out_ch.duration_ticks = res.duration_ticks;
    assign out_ch.duration_us = res.duration_us;
endmodule
